### src/assert_macros.svh
// Assertion macros for the checker file of the prefix-code integer codec.
// No dependencies; include guard below.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define VLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define VLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/vlc_pkg.sv
// Shared types and constants for the prefix-code integer codec.
// No dependencies; used by every module of the block.
`default_nettype none

package vlc_pkg;

  // op field
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // kind field
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam int unsigned MaxBytes = 5;

  // Range limits of the encoded forms
  localparam logic [31:0] POS_MAX   = 32'h1fff_ffff;
  localparam logic [31:0] POS1_MAX  = 32'h0000_007f;
  localparam logic [31:0] POS2_MAX  = 32'h0000_1fff;
  localparam logic [31:0] POS3_MAX  = 32'h001f_ffff;
  localparam logic [31:0] EXT2_MAX  = 32'h0000_07ff;
  localparam logic [31:0] EXT3_MAX  = 32'h0007_ffff;
  localparam logic [31:0] EXT4_MAX  = 32'h07ff_ffff;
  localparam logic [7:0]  EXT5_HDR  = 8'hf8;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;  // bytes[0] goes out first
    logic [2:0]               cnt;    // 1..5
  } enc_t;

  typedef struct packed {
    logic        valid;  // current byte completes a word
    logic [31:0] word;
  } dec_res_t;

endpackage

`default_nettype wire

### src/vlc_encoder.sv
// Encoder: splits a 32-bit word into its 1 to 5 byte prefix-coded form.
// Depends on vlc_pkg.
`default_nettype none

module vlc_encoder (
  input  wire logic [31:0]  value_i,
  output vlc_pkg::enc_t     enc_o
);

  logic [31:0] inv;

  assign inv = ~value_i;

  always_comb begin
    enc_o = '0;
    if (value_i <= vlc_pkg::POS_MAX) begin
      if (value_i <= vlc_pkg::POS1_MAX) begin
        enc_o.cnt      = 3'd1;
        enc_o.bytes[0] = value_i[7:0];
      end else if (value_i <= vlc_pkg::POS2_MAX) begin
        enc_o.cnt      = 3'd2;
        enc_o.bytes[0] = {3'b100, value_i[12:8]};
        enc_o.bytes[1] = value_i[7:0];
      end else if (value_i <= vlc_pkg::POS3_MAX) begin
        enc_o.cnt      = 3'd3;
        enc_o.bytes[0] = {3'b101, value_i[20:16]};
        enc_o.bytes[1] = value_i[15:8];
        enc_o.bytes[2] = value_i[7:0];
      end else begin
        enc_o.cnt      = 3'd4;
        enc_o.bytes[0] = {3'b110, value_i[28:24]};
        enc_o.bytes[1] = value_i[23:16];
        enc_o.bytes[2] = value_i[15:8];
        enc_o.bytes[3] = value_i[7:0];
      end
    end else begin
      // extended forms carry the inverted word
      if (inv <= vlc_pkg::EXT2_MAX) begin
        enc_o.cnt      = 3'd2;
        enc_o.bytes[0] = {5'b11100, inv[10:8]};
        enc_o.bytes[1] = inv[7:0];
      end else if (inv <= vlc_pkg::EXT3_MAX) begin
        enc_o.cnt      = 3'd3;
        enc_o.bytes[0] = {5'b11101, inv[18:16]};
        enc_o.bytes[1] = inv[15:8];
        enc_o.bytes[2] = inv[7:0];
      end else if (inv <= vlc_pkg::EXT4_MAX) begin
        enc_o.cnt      = 3'd4;
        enc_o.bytes[0] = {5'b11110, inv[26:24]};
        enc_o.bytes[1] = inv[23:16];
        enc_o.bytes[2] = inv[15:8];
        enc_o.bytes[3] = inv[7:0];
      end else begin
        enc_o.cnt      = 3'd5;
        enc_o.bytes[0] = vlc_pkg::EXT5_HDR;
        enc_o.bytes[1] = inv[31:24];
        enc_o.bytes[2] = inv[23:16];
        enc_o.bytes[3] = inv[15:8];
        enc_o.bytes[4] = inv[7:0];
      end
    end
  end

endmodule

`default_nettype wire

### src/vlc_decoder.sv
// Decoder: header, accumulator and remaining-byte count of the run being decoded.
// Depends on vlc_pkg.
`default_nettype none

module vlc_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,   // consume byte_i this cycle
  input  wire logic [7:0]   byte_i,
  output vlc_pkg::dec_res_t res_o     // result for byte_i, valid before step
);

  logic [7:0]  header_q, header_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  due_q, due_d;
  logic [31:0] acc_shift;

  assign acc_shift = {acc_q[23:0], byte_i};

  always_comb begin
    header_d    = header_q;
    acc_d       = acc_q;
    due_d       = due_q;
    res_o.valid = 1'b0;
    res_o.word  = '0;
    if (due_q == 3'd0) begin
      header_d = byte_i;
      if (!byte_i[7]) begin
        acc_d       = {24'd0, byte_i};
        res_o.valid = 1'b1;
        res_o.word  = {24'd0, byte_i};
      end else if (byte_i[6:5] != 2'b11) begin
        acc_d = {27'd0, byte_i[4:0]};
        due_d = {1'b0, byte_i[6:5]} + 3'd1;
      end else begin
        // full-word form drops the spare header bits
        acc_d = (byte_i[4:3] == 2'b11) ? 32'd0 : {29'd0, byte_i[2:0]};
        due_d = {1'b0, byte_i[4:3]} + 3'd1;
      end
    end else begin
      acc_d = acc_shift;
      due_d = due_q - 3'd1;
      if (due_q == 3'd1) begin
        res_o.valid = 1'b1;
        res_o.word  = (header_q[7:5] == 3'b111) ? ~acc_shift : acc_shift;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
      acc_q    <= '0;
      due_q    <= '0;
    end else if (step_i) begin
      header_q <= header_d;
      acc_q    <= acc_d;
      due_q    <= due_d;
    end
  end

endmodule

`default_nettype wire

### src/varint_codec.sv
// Prefix-code integer codec, 1 to 5 bytes per 32-bit word. An item enters an
// input register (encode items are split into bytes on the way in) and its
// results leave through a single output register. Decode bytes are taken at
// one per cycle while the output register can take each result; a decode
// result appears when the last byte of a run is consumed. An encode item holds
// the input register until its 1 to 5 bytes have gone out, one byte per cycle
// while the output is not stalled, and input is held off with ready meanwhile.
// Depends on vlc_pkg, vlc_encoder and vlc_decoder.
`default_nettype none

module varint_codec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [31:0] value_i,
  input  wire logic [7:0]  byte_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       byte_out_o,
  output logic [31:0]      word_out_o,
  output logic             last_o
);

  vlc_pkg::enc_t     enc_d, enc_q;
  vlc_pkg::dec_res_t dec_res;

  logic        in_valid_q;
  logic        op_q;
  logic [7:0]  din_q;
  logic [2:0]  idx_q;
  logic        out_valid_q;
  logic        kind_q, last_q;
  logic [7:0]  byte_q;
  logic [31:0] word_q;

  logic is_dec, out_free, enc_last, produce, advance, load_out;

  vlc_encoder u_enc (
    .value_i (value_i),
    .enc_o   (enc_d)
  );

  vlc_decoder u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && is_dec),
    .byte_i (din_q),
    .res_o  (dec_res)
  );

  assign is_dec   = (op_q == vlc_pkg::OP_DECODE);
  assign out_free = !out_valid_q || out_ready_i;
  assign enc_last = (idx_q == enc_q.cnt - 3'd1);
  assign produce  = in_valid_q && (!is_dec || dec_res.valid);
  assign load_out = produce && out_free;
  // a decode byte that gives no result never waits on the output side
  assign advance  = in_valid_q && (is_dec ? (!dec_res.valid || out_free)
                                          : (out_free && enc_last));
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (load_out && !is_dec) begin
        idx_q <= enc_last ? 3'd0 : idx_q + 3'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_i;
      enc_q <= enc_d;
      din_q <= byte_in_i;
    end
    if (load_out) begin
      if (is_dec) begin
        kind_q <= vlc_pkg::KIND_WORD;
        byte_q <= '0;
        word_q <= dec_res.word;
        last_q <= 1'b1;
      end else begin
        kind_q <= vlc_pkg::KIND_BYTE;
        byte_q <= enc_q.bytes[idx_q];
        word_q <= '0;
        last_q <= enc_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign byte_out_o  = byte_q;
  assign word_out_o  = word_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### src/vlc_checker.sv
// Port-level checks for varint_codec, attached by the bind below.
// Depends on vlc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vlc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        kind_o,
  input wire logic [7:0]  byte_out_o,
  input wire logic [31:0] word_out_o,
  input wire logic        last_o
);

  logic        out_stall;
  logic        is_word;
  logic        is_byte;
  logic [41:0] payload;

  assign out_stall = out_valid_o && !out_ready_i;
  assign is_word   = out_valid_o && (kind_o == vlc_pkg::KIND_WORD);
  assign is_byte   = out_valid_o && (kind_o == vlc_pkg::KIND_BYTE);
  assign payload   = {kind_o, byte_out_o, word_out_o, last_o};

  // stalled result holds
  `VLC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(payload))

  // decoded words are single results with a clear byte field
  `VLC_ASSERT_NOW(a_word_last, clk_i, rst_ni, is_word, last_o && byte_out_o == 8'd0)

  `VLC_ASSERT_NOW(a_byte_noword, clk_i, rst_ni, is_byte, word_out_o == 32'd0)

  // an encoded run streams without gaps once started
  `VLC_ASSERT_NEXT(a_run_cont, clk_i, rst_ni, is_byte && out_ready_i && !last_o, is_byte)

endmodule

bind varint_codec vlc_checker u_vlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .byte_out_o  (byte_out_o),
  .word_out_o  (word_out_o),
  .last_o      (last_o)
);

`default_nettype wire
